>>> sv/bcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcm_pkg
// Types and constants shared by the contour marker modules.
// ----------------------------------------------------------------------------
package bcm_pkg;

  localparam int PIX_BITS       = 8;
  localparam int CFG_DATA_BITS  = 11;
  localparam int CFG_INDEX_BITS = 2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_MODE   = 2'd2;

  localparam logic [CFG_DATA_BITS-1:0] RESET_WIDTH  = 11'd640;
  localparam logic [CFG_DATA_BITS-1:0] RESET_HEIGHT = 11'd480;

  // Item kinds and neighbour modes.
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic MODE_FOUR  = 1'b0;
  localparam logic MODE_EIGHT = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [PIX_BITS-1:0] pixel_value;
  } in_item_t;

  typedef struct packed {
    logic [PIX_BITS-1:0] out_value;
    logic                frame_end;
  } out_item_t;

  // One push of a pixel into the line stores and the window.
  typedef struct packed {
    logic                push;       // a pixel enters the store read stage this cycle
    logic                prod;       // the push completes a result
    logic                on_border;  // that result lies on the frame border
    logic                last;       // that result is the frame's last pixel
    logic                use_mid;    // single-row frame drain: centre comes from the store
    logic [PIX_BITS-1:0] pixel;
  } push_info_t;

endpackage

>>> sv/bcm_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcm_stream_if
// Valid/ready stream channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface bcm_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/bcm_line_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcm_line_store
// The two row stores: one write and one registered read per cycle each.
// ----------------------------------------------------------------------------
module bcm_line_store #(
  parameter int DEPTH = 1024
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [$clog2(DEPTH)-1:0]     rd_addr,
  output logic [bcm_pkg::PIX_BITS-1:0] rd_top_r,
  output logic [bcm_pkg::PIX_BITS-1:0] rd_mid_r,
  input  logic                         wr_en,
  input  logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  logic [bcm_pkg::PIX_BITS-1:0] wr_top,
  input  logic [bcm_pkg::PIX_BITS-1:0] wr_mid
);
  import bcm_pkg::*;

  logic [PIX_BITS-1:0] older_mem [DEPTH];
  logic [PIX_BITS-1:0] newer_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      older_mem[wr_addr] <= wr_top;
      newer_mem[wr_addr] <= wr_mid;
    end
    if (rd_en) begin
      rd_top_r <= older_mem[rd_addr];
      rd_mid_r <= newer_mem[rd_addr];
    end
  end

endmodule

>>> sv/bcm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcm_ctrl
// Configuration registers, frame position counters and drain bookkeeping.
// ----------------------------------------------------------------------------
module bcm_ctrl #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bcm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [bcm_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                acc,
  input  bcm_pkg::in_item_t                   item,
  output bcm_pkg::push_info_t                 info,
  output logic [$clog2(MAX_WIDTH)-1:0]        push_col,
  output logic                                neighbour_mode
);
  import bcm_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int PW = $clog2(MAX_WIDTH + 2);

  logic [CFG_DATA_BITS-1:0] width_r, height_r;
  logic                     mode_r;
  logic [CW-1:0]            col_r, col_nxt, ocol_r, ocol_nxt, wlast;
  logic [RW-1:0]            row_r, row_nxt, orow_r, orow_nxt, hlast;
  logic [PW-1:0]            pend_r, pend_nxt;
  logic                     draining, col_wrap, final_px, restart;

  // Effective frame size, held as the index of the last column and row.
  always_comb begin
    if (width_r == '0) begin
      wlast = '0;
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      wlast = CW'(MAX_WIDTH - 1);
    end else begin
      wlast = CW'(32'(width_r) - 32'd1);
    end
    if (height_r == '0) begin
      hlast = '0;
    end else if (32'(height_r) > 32'(MAX_HEIGHT)) begin
      hlast = RW'(MAX_HEIGHT - 1);
    end else begin
      hlast = RW'(32'(height_r) - 32'd1);
    end
  end

  assign draining       = (pend_r != '0);
  assign col_wrap       = (col_r == wlast);
  assign final_px       = (row_r == hlast) && col_wrap;
  assign push_col       = col_r;
  assign neighbour_mode = mode_r;

  always_comb begin
    // While draining every beat pushes a background pixel and releases one result.
    info.push      = acc && (draining || (item.kind == KIND_PIXEL));
    info.pixel     = draining ? '0 : item.pixel_value;
    info.prod      = draining || (row_r >= RW'(2)) || ((row_r == RW'(1)) && (col_r != '0));
    info.on_border = (orow_r == '0) || (ocol_r == '0) || (orow_r == hlast) ||
                     (ocol_r == wlast);
    info.last      = (orow_r == hlast) && (ocol_r == wlast);
    // In a single-row frame every drain beat takes its centre from the store
    // read, which already holds the wanted pixel.
    info.use_mid   = draining && (hlast == '0);

    col_nxt  = col_r;
    row_nxt  = row_r;
    ocol_nxt = ocol_r;
    orow_nxt = orow_r;
    pend_nxt = pend_r;
    restart  = 1'b0;
    if (info.push) begin
      col_nxt = col_wrap ? '0 : col_r + 1'b1;
      if (info.prod) begin
        if (ocol_r == wlast) begin
          ocol_nxt = '0;
          orow_nxt = orow_r + 1'b1;
        end else begin
          ocol_nxt = ocol_r + 1'b1;
        end
      end
      if (draining) begin
        pend_nxt = pend_r - 1'b1;
        restart  = (pend_r == PW'(1));
      end else if (final_px) begin
        pend_nxt = (hlast == '0) ? PW'(wlast) + PW'(1) : PW'(wlast) + PW'(2);
      end else if (col_wrap) begin
        row_nxt = row_r + 1'b1;
      end
    end
    if (restart) begin
      col_nxt  = '0;
      row_nxt  = '0;
      ocol_nxt = '0;
      orow_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RESET_WIDTH;
      height_r <= RESET_HEIGHT;
      mode_r   <= MODE_FOUR;
      col_r    <= '0;
      row_r    <= '0;
      ocol_r   <= '0;
      orow_r   <= '0;
      pend_r   <= '0;
    end else if (cfg_we && ((cfg_index == CFG_IDX_WIDTH) || (cfg_index == CFG_IDX_HEIGHT) ||
                            (cfg_index == CFG_IDX_MODE))) begin
      case (cfg_index)
        CFG_IDX_WIDTH:  width_r  <= cfg_data;
        CFG_IDX_HEIGHT: height_r <= cfg_data;
        default:        mode_r   <= cfg_data[0];
      endcase
      col_r  <= '0;
      row_r  <= '0;
      ocol_r <= '0;
      orow_r <= '0;
      pend_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      ocol_r <= ocol_nxt;
      orow_r <= orow_nxt;
      pend_r <= pend_nxt;
    end
  end

`ifndef SYNTHESIS
  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= wlast)
    else $error("column counter beyond the row");
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= PW'(wlast) + PW'(2))
    else $error("pending count beyond one row plus one pixel");
  a_orow_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    orow_r <= hlast)
    else $error("result row beyond the frame");
`endif

endmodule

>>> sv/bcm_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcm_window
// Store read stage, 3x3 window, contour test and the result register.
// ----------------------------------------------------------------------------
module bcm_window #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bcm_pkg::push_info_t           info,
  input  logic [$clog2(MAX_WIDTH)-1:0]  push_col,
  input  logic                          neighbour_mode,
  output logic                          a_free,
  input  logic                          out_ready,
  output logic                          out_valid,
  output bcm_pkg::out_item_t            out_item
);
  import bcm_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  logic                ld_valid_r, ld_prod_r, ld_border_r, ld_last_r, ld_use_mid_r;
  logic [CW-1:0]       ld_col_r;
  logic [PIX_BITS-1:0] ld_pix_r;
  logic                byp_r;
  logic [PIX_BITS-1:0] byp_top_r, byp_mid_r;
  logic [PIX_BITS-1:0] rd_top, rd_mid, cur_top, cur_mid, centre, res;
  logic                out_free, a_move, bg;
  logic                out_valid_r;
  out_item_t           out_item_r;
  logic [2:0][2:0][PIX_BITS-1:0] win_r, win_nxt;

  assign out_free  = !out_valid_r || out_ready;
  assign a_move    = ld_valid_r && (!ld_prod_r || out_free);
  assign a_free    = !ld_valid_r || a_move;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // A push to the column that the beat ahead is writing right now reads the
  // store before that write lands, so its values are forwarded.
  assign cur_top = byp_r ? byp_top_r : rd_top;
  assign cur_mid = byp_r ? byp_mid_r : rd_mid;

  bcm_line_store #(.DEPTH(MAX_WIDTH)) u_store (
    .clk      (clk),
    .rd_en    (info.push),
    .rd_addr  (push_col),
    .rd_top_r (rd_top),
    .rd_mid_r (rd_mid),
    .wr_en    (a_move),
    .wr_addr  (ld_col_r),
    .wr_top   (cur_mid),
    .wr_mid   (ld_pix_r)
  );

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r][0] = win_r[r][1];
      win_nxt[r][1] = win_r[r][2];
    end
    win_nxt[0][2] = cur_top;
    win_nxt[1][2] = cur_mid;
    win_nxt[2][2] = ld_pix_r;

    centre = ld_use_mid_r ? cur_mid : win_nxt[1][1];
    bg = (win_nxt[0][1] == '0) || (win_nxt[2][1] == '0) ||
         (win_nxt[1][0] == '0) || (win_nxt[1][2] == '0);
    if (neighbour_mode == MODE_EIGHT) begin
      bg = bg || (win_nxt[0][0] == '0) || (win_nxt[0][2] == '0) ||
           (win_nxt[2][0] == '0) || (win_nxt[2][2] == '0);
    end
    if (centre == '0) begin
      res = '0;
    end else if (ld_border_r || bg) begin
      res = PIX_BITS'(1);
    end else begin
      res = centre;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      win_r       <= '0;
    end else begin
      if (a_move) begin
        win_r <= win_nxt;
      end
      if (info.push) begin
        ld_valid_r <= 1'b1;
      end else if (a_move) begin
        ld_valid_r <= 1'b0;
      end
      if (a_move && ld_prod_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (info.push) begin
      ld_col_r     <= push_col;
      ld_pix_r     <= info.pixel;
      ld_prod_r    <= info.prod;
      ld_border_r  <= info.on_border;
      ld_last_r    <= info.last;
      ld_use_mid_r <= info.use_mid;
      byp_r        <= a_move && (ld_col_r == push_col);
      byp_top_r    <= cur_mid;
      byp_mid_r    <= ld_pix_r;
    end
    if (a_move && ld_prod_r) begin
      out_item_r.out_value <= res;
      out_item_r.frame_end <= ld_last_r;
    end
  end

`ifndef SYNTHESIS
  a_result_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(a_move && ld_prod_r))
    else $error("result register loaded without a producing push");
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    ld_valid_r && !a_move |-> ld_prod_r && out_valid_r && !out_ready)
    else $error("read stage stalled without a waiting result");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ld_valid_r && !a_move |=> ld_valid_r && $stable(ld_col_r))
    else $error("stalled read stage lost its beat");
`endif

endmodule

>>> sv/binary_contour_marker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_contour_marker
// 3x3 boundary extraction on a raster pixel stream with two row stores.
//
//   channel  direction  payload                       handshake
//   in_ch    sink       kind, pixel_value             valid/ready
//   out_ch   source     out_value, frame_end          valid/ready
//   cfg      write      cfg_index, cfg_data           cfg_we, no wait
//
// One beat is accepted per clock while the read stage is free; a producing beat
// is registered in the store read stage and then in the result register.
// Results trail their pixel by one row plus one pixel of the stream, and one
// drain beat per pending result (row width plus one, or just the row width
// in a single-row frame) flushes the frame.
// Reset is synchronous; the row stores are not cleared and need no sweep.
// A waiting result holds only a producing beat in the read stage; beats that
// make no result still flow.
// ----------------------------------------------------------------------------
module binary_contour_marker #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [bcm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [bcm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  bcm_stream_if.sink                         in_ch,
  bcm_stream_if.source                       out_ch
);
  import bcm_pkg::*;

  in_item_t                   item;
  out_item_t                  res_item;
  push_info_t                 info;
  logic [$clog2(MAX_WIDTH)-1:0] push_col;
  logic                       neighbour_mode, a_free, acc, res_valid;

  assign item         = in_ch.data;
  assign in_ch.ready  = a_free;
  assign acc          = in_ch.valid && a_free;
  assign out_ch.valid = res_valid;
  assign out_ch.data  = res_item;

  bcm_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .acc            (acc),
    .item           (item),
    .info           (info),
    .push_col       (push_col),
    .neighbour_mode (neighbour_mode)
  );

  bcm_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk            (clk),
    .rst_n          (rst_n),
    .info           (info),
    .push_col       (push_col),
    .neighbour_mode (neighbour_mode),
    .a_free         (a_free),
    .out_ready      (out_ch.ready),
    .out_valid      (res_valid),
    .out_item       (res_item)
  );

endmodule
